// ----- src/lru_frame_replacement_stack_unit_assert.svh -----
// Assertion macros shared by the checker of the LRU replacement stack.
// Each macro expects signals named clock and reset in the scope that uses it.
`ifndef LRU_FRAME_REPLACEMENT_STACK_UNIT_ASSERT_SVH
`define LRU_FRAME_REPLACEMENT_STACK_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRUS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRUS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/lrus_pkg.sv -----
// Package of the LRU frame replacement stack: payload types, codes and sizes.
// Used by the cell chain, the top level and the checker.
package lrus_pkg;

   localparam int NUM_FRAMES_DEFAULT = 64;
   localparam int FRAME_WIDTH        = 6;
   localparam int STATUS_WIDTH       = 2;

   localparam logic OP_REFERENCE = 1'b0;
   localparam logic OP_EVICT     = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   typedef logic [FRAME_WIDTH-1:0] frame_type;

   typedef struct packed {
      logic      operation;
      frame_type frame_number;
   } req_payload_type;

   typedef struct packed {
      frame_type                victim_frame;
      logic                     victim_valid;
      logic [STATUS_WIDTH-1:0]  status;
   } rsp_payload_type;

   // Command from the top level to the stack, already qualified by the transfer.
   typedef struct packed {
      logic      evict;
      logic      reference;
      frame_type frame;
   } stack_cmd_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic      evict;
      logic      reference;
      logic      hit;
      frame_type frame;
   } cell_ctrl_type;

   // What the stack reports about its current contents.
   typedef struct packed {
      frame_type lru_frame;
      logic      lru_valid;
      logic      full;
      logic      hit;
   } stack_status_type;

endpackage

// ----- src/lrus_chan_if.sv -----
// Valid/ready channel that carries one payload per transfer.
// Payload type is given per instance, normally from lrus_pkg.
interface lrus_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/lru_frame_replacement_stack_unit.sv -----
// Exact LRU stack of page frames. Each transfer on req_chan either references a frame
// (operation 0), which moves it to the most recent end or appends it there, or evicts
// the least recent frame (operation 1). Every request gives exactly one response on
// rsp_chan, in the cycle after its transfer, held in an output register. The unit takes
// one request per cycle as long as responses are drained: all cells compare their
// frame against the request in the same cycle, a parallel prefix OR finds the cells
// that shift, and the chain updates at the clock edge of the transfer. A reference
// to a new frame while all NUM_FRAMES cells are occupied is dropped with status 2;
// an evict on an empty stack returns status 1. No clearing pass follows reset.
// Depends on lrus_pkg, lrus_chan_if, lrus_stack and lrus_cell.
module lru_frame_replacement_stack_unit #(
   parameter int NUM_FRAMES = lrus_pkg::NUM_FRAMES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   lrus_chan_if.sink   req_chan,
   lrus_chan_if.source rsp_chan
);

   logic                       transfer;
   lrus_pkg::stack_cmd_type    cmd;
   lrus_pkg::stack_status_type stack_status;
   lrus_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign transfer       = req_chan.valid && req_chan.ready;

   assign cmd.evict     = transfer && (req_chan.payload.operation == lrus_pkg::OP_EVICT);
   assign cmd.reference = transfer && (req_chan.payload.operation == lrus_pkg::OP_REFERENCE);
   assign cmd.frame     = req_chan.payload.frame_number;

   lrus_stack #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (stack_status)
   );

   always_comb begin
      rsp_payload_in.victim_frame = '0;
      rsp_payload_in.victim_valid = 1'b0;
      rsp_payload_in.status       = lrus_pkg::STATUS_OK;
      if (req_chan.payload.operation == lrus_pkg::OP_EVICT) begin
         if (stack_status.lru_valid) begin
            rsp_payload_in.victim_frame = stack_status.lru_frame;
            rsp_payload_in.victim_valid = 1'b1;
         end else begin
            rsp_payload_in.status = lrus_pkg::STATUS_EMPTY;
         end
      end else if (!stack_status.hit && stack_status.full) begin
         rsp_payload_in.status = lrus_pkg::STATUS_FULL;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (transfer) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         rsp_payload_ff <= rsp_payload_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

// ----- src/lrus_cell.sv -----
// One position of the recency chain: a frame number and an occupied flag.
// Uses lrus_pkg; instantiated in a row by lrus_stack.
module lrus_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lrus_pkg::cell_ctrl_type ctrl,
   input  lrus_pkg::frame_type   up_frame,
   input  logic                  up_valid,
   input  logic                  below_valid,
   input  logic                  prefix_hit,
   output lrus_pkg::frame_type   frame,
   output logic                  valid,
   output logic                  match
);

   lrus_pkg::frame_type frame_ff, frame_in;
   logic                valid_ff, valid_in;
   logic                tail;
   logic                first_free;

   assign match      = valid_ff && (frame_ff == ctrl.frame);
   // The tail is the most recent occupied position; the first free one sits just above it.
   assign tail       = valid_ff && !up_valid;
   assign first_free = !valid_ff && below_valid;

   always_comb begin
      frame_in = frame_ff;
      valid_in = valid_ff;
      if (ctrl.evict) begin
         frame_in = up_frame;
         valid_in = up_valid;
      end else if (ctrl.reference) begin
         if (ctrl.hit) begin
            if (tail) begin
               frame_in = ctrl.frame;
            end else if (prefix_hit) begin
               frame_in = up_frame;
               valid_in = up_valid;
            end
         end else if (first_free) begin
            frame_in = ctrl.frame;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign frame = frame_ff;
   assign valid = valid_ff;

endmodule

// ----- src/lrus_stack.sv -----
// Row of recency cells, least recent at position zero, plus the hit prefix tree.
// Uses lrus_pkg and lrus_cell.
module lrus_stack #(
   parameter int NUM_FRAMES = lrus_pkg::NUM_FRAMES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lrus_pkg::stack_cmd_type  cmd,
   output lrus_pkg::stack_status_type status
);

   localparam int LEVELS = $clog2(NUM_FRAMES);

   lrus_pkg::frame_type     cell_frame [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]   cell_valid;
   logic [NUM_FRAMES-1:0]   cell_match;
   wire  [NUM_FRAMES-1:0]   prefix_lvl [LEVELS+1];
   lrus_pkg::cell_ctrl_type ctrl;

   // Parallel prefix OR: bit i is set when the referenced frame sits at or below position i.
   assign prefix_lvl[0] = cell_match;
   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_bit
         if (i >= (1 << l)) begin : g_or
            assign prefix_lvl[l+1][i] = prefix_lvl[l][i] | prefix_lvl[l][i - (1 << l)];
         end else begin : g_pass
            assign prefix_lvl[l+1][i] = prefix_lvl[l][i];
         end
      end
   end

   assign ctrl.evict     = cmd.evict;
   assign ctrl.reference = cmd.reference;
   assign ctrl.hit       = prefix_lvl[LEVELS][NUM_FRAMES-1];
   assign ctrl.frame     = cmd.frame;

   for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
      lrus_pkg::frame_type up_frame;
      logic                up_valid;
      logic                below_valid;

      if (i == NUM_FRAMES - 1) begin : g_top
         assign up_frame = '0;
         assign up_valid = 1'b0;
      end else begin : g_mid
         assign up_frame = cell_frame[i+1];
         assign up_valid = cell_valid[i+1];
      end

      if (i == 0) begin : g_bottom
         assign below_valid = 1'b1;
      end else begin : g_upper
         assign below_valid = cell_valid[i-1];
      end

      lrus_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .up_frame    (up_frame),
         .up_valid    (up_valid),
         .below_valid (below_valid),
         .prefix_hit  (prefix_lvl[LEVELS][i]),
         .frame       (cell_frame[i]),
         .valid       (cell_valid[i]),
         .match       (cell_match[i])
      );
   end

   assign status.lru_frame = cell_frame[0];
   assign status.lru_valid = cell_valid[0];
   assign status.full      = cell_valid[NUM_FRAMES-1];
   assign status.hit       = ctrl.hit;

endmodule

// ----- src/lrus_checker.sv -----
// Port-level checker for the LRU frame replacement stack, bound to the top level.
// Depends on lrus_pkg and the assertion macros header.
`include "lru_frame_replacement_stack_unit_assert.svh"

module lrus_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input lrus_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input lrus_pkg::rsp_payload_type rsp_payload
);

   logic req_transfer;
   logic evict_transfer;
   logic reference_transfer;

   assign req_transfer       = req_valid && req_ready;
   assign evict_transfer     = req_transfer && (req_payload.operation == lrus_pkg::OP_EVICT);
   assign reference_transfer = req_transfer &&
                               (req_payload.operation == lrus_pkg::OP_REFERENCE);

   // An evict either returns a victim or reports the empty stack, on the next cycle.
   `LRUS_ASSERT_NEXT(evict_answered, evict_transfer, rsp_valid && (rsp_payload.victim_valid || rsp_payload.status == lrus_pkg::STATUS_EMPTY), "evict response missing or wrong kind")

   // A reference never produces a victim or an empty-stack status.
   `LRUS_ASSERT_NEXT(reference_answered, reference_transfer, rsp_valid && !rsp_payload.victim_valid && rsp_payload.status != lrus_pkg::STATUS_EMPTY, "reference response missing or wrong kind")

   // A failed response carries no victim.
   `LRUS_ASSERT_NOW(no_victim_on_error, rsp_valid && rsp_payload.status != lrus_pkg::STATUS_OK, !rsp_payload.victim_valid && rsp_payload.victim_frame == '0, "victim reported with error status")

   // A stalled response holds.
   `LRUS_ASSERT_NEXT(rsp_held, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled response changed")

endmodule

bind lru_frame_replacement_stack_unit lrus_checker u_lrus_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_payload (req_chan.payload),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

// ----- tb/lru_frame_replacement_stack_unit_tb.sv -----
// Self-checking testbench for the LRU frame replacement stack.
// It drives lru_frame_replacement_stack_unit through lrus_chan_if with a directed table,
// then random bursts, and checks every response against its own recency queue.
`timescale 1ns / 100ps

module lru_frame_replacement_stack_unit_tb;

   // The depth is the block's default, which equals the count of frame numbers,
   // so a full stack already holds every frame and no reference is turned away.
   localparam int STACK_DEPTH  = lrus_pkg::NUM_FRAMES_DEFAULT;
   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int DIRECTED_ROWS = 14;

   typedef struct packed {
      logic                      operation;
      lrus_pkg::frame_type       frame;
      bit                        fixed;
      lrus_pkg::rsp_payload_type result;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lrus_chan_if #(.payload_type(lrus_pkg::req_payload_type)) req_if ();
   lrus_chan_if #(.payload_type(lrus_pkg::rsp_payload_type)) rsp_if ();

   lru_frame_replacement_stack_unit #(
      .NUM_FRAMES(STACK_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   lrus_pkg::frame_type       lru_order[$];
   lrus_pkg::rsp_payload_type expected_responses[$];
   bit              quiet_stretch = 1'b0;
   int              error_count = 0;
   int              cycle_count = 0;
   int              sent_count = 0;
   int              checked_count = 0;
   int              eviction_count = 0;
   int              empty_evict_count = 0;
   int              full_drop_count = 0;

   // Walks through a short history by hand: empty evicts, a move to the
   // most recent end, the extremes of the frame number and a full drain.
   directed_row_type directed_rows[DIRECTED_ROWS] = '{
      '{lrus_pkg::OP_EVICT,     6'd0,  1'b1, '{6'd0,  1'b0, lrus_pkg::STATUS_EMPTY}},
      '{lrus_pkg::OP_REFERENCE, 6'd0,  1'b1, '{6'd0,  1'b0, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_REFERENCE, 6'd63, 1'b1, '{6'd0,  1'b0, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_REFERENCE, 6'd0,  1'b1, '{6'd0,  1'b0, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_REFERENCE, 6'd42, 1'b1, '{6'd0,  1'b0, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_REFERENCE, 6'd21, 1'b1, '{6'd0,  1'b0, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_REFERENCE, 6'd63, 1'b1, '{6'd0,  1'b0, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_EVICT,     6'd0,  1'b1, '{6'd0,  1'b1, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_EVICT,     6'd63, 1'b1, '{6'd42, 1'b1, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_REFERENCE, 6'd21, 1'b0, '{6'd0,  1'b0, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_EVICT,     6'd0,  1'b1, '{6'd63, 1'b1, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_EVICT,     6'd0,  1'b1, '{6'd21, 1'b1, lrus_pkg::STATUS_OK}},
      '{lrus_pkg::OP_EVICT,     6'd0,  1'b1, '{6'd0,  1'b0, lrus_pkg::STATUS_EMPTY}},
      '{lrus_pkg::OP_EVICT,     6'd63, 1'b1, '{6'd0,  1'b0, lrus_pkg::STATUS_EMPTY}}
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d responses outstanding", $time,
                  expected_responses.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Applies one request to the recency queue and returns the response it causes.
   function automatic lrus_pkg::rsp_payload_type lru_stack_apply(logic operation,
                                                                 lrus_pkg::frame_type frame);
      lrus_pkg::rsp_payload_type result;
      int              hit_at;
      result = '0;
      result.status = lrus_pkg::STATUS_OK;
      hit_at = -1;
      if (operation == lrus_pkg::OP_EVICT) begin
         if (lru_order.size() == 0) begin
            result.status = lrus_pkg::STATUS_EMPTY;
         end else begin
            result.victim_frame = lru_order.pop_front();
            result.victim_valid = 1'b1;
         end
      end else begin
         foreach (lru_order[i]) begin
            if (hit_at < 0 && lru_order[i] == frame) hit_at = i;
         end
         if (hit_at >= 0) begin
            lru_order.delete(hit_at);
            lru_order.push_back(frame);
         end else if (lru_order.size() < STACK_DEPTH) begin
            lru_order.push_back(frame);
         end else begin
            result.status = lrus_pkg::STATUS_FULL;
         end
      end
      return result;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_stretch || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic lrus_pkg::frame_type any_frame();
      return lrus_pkg::frame_type'($urandom_range(0, 63));
   endfunction

   // Called at a falling edge; returns at a falling edge after the transfer
   // and any idle cycles that follow it.
   task automatic send_request(input logic operation, input lrus_pkg::frame_type frame,
                               input bit use_fixed = 1'b0,
                               input lrus_pkg::rsp_payload_type fixed_rsp = '0);
      lrus_pkg::rsp_payload_type predicted;
      int              gap;
      req_if.valid = 1'b1;
      req_if.payload.operation = operation;
      req_if.payload.frame_number = frame;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = lru_stack_apply(operation, frame);
      expected_responses.push_back(use_fixed ? fixed_rsp : predicted);
      sent_count++;
      if (predicted.victim_valid) eviction_count++;
      if (predicted.status == lrus_pkg::STATUS_EMPTY) empty_evict_count++;
      if (predicted.status == lrus_pkg::STATUS_FULL) full_drop_count++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid = 1'b0;
         req_if.payload = lrus_pkg::req_payload_type'($urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic flag_mismatch(input string field, input logic [7:0] expected_value,
                                input logic [7:0] actual_value);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
               expected_value, actual_value);
   endtask

   always @(posedge clock) begin
      lrus_pkg::rsp_payload_type oldest;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_responses.size() == 0) begin
            error_count++;
            $display("%0t: response with nothing outstanding, got %h", $time,
                     rsp_if.payload);
         end else begin
            oldest = expected_responses.pop_front();
            checked_count++;
            if (rsp_if.payload.victim_frame !== oldest.victim_frame)
               flag_mismatch("victim_frame", 8'(oldest.victim_frame),
                             8'(rsp_if.payload.victim_frame));
            if (rsp_if.payload.victim_valid !== oldest.victim_valid)
               flag_mismatch("victim_valid", 8'(oldest.victim_valid),
                             8'(rsp_if.payload.victim_valid));
            if (rsp_if.payload.status !== oldest.status)
               flag_mismatch("status", 8'(oldest.status), 8'(rsp_if.payload.status));
         end
      end
   end

   // Response side: ready for a random run, then stalled for a random gap.
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = 1'b1;
         repeat ($urandom_range(0, 11)) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_if.ready = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   end

   initial begin
      int                  random_start;
      int                  tries;
      lrus_pkg::frame_type base;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].operation, directed_rows[i].frame,
                      directed_rows[i].fixed, directed_rows[i].result);

      random_start = sent_count;
      while (sent_count - random_start < RANDOM_ITEMS) begin
         quiet_stretch = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // A small working set, so most references hit and move.
               base = any_frame();
               repeat ($urandom_range(8, 20)) begin
                  if ($urandom_range(0, 4) == 0) begin
                     send_request(lrus_pkg::OP_EVICT, any_frame());
                  end else begin
                     send_request(lrus_pkg::OP_REFERENCE,
                                  lrus_pkg::frame_type'(base + $urandom_range(0, 5)));
                  end
               end
            end
            4, 5: begin
               // Fill the stack toward full, then keep referencing random frames.
               tries = 0;
               while (lru_order.size() < STACK_DEPTH && tries < 200) begin
                  send_request(lrus_pkg::OP_REFERENCE, any_frame());
                  tries++;
               end
               repeat ($urandom_range(4, 12))
                  send_request(lrus_pkg::OP_REFERENCE, any_frame());
            end
            6, 7: begin
               // Drain to empty and evict past it.
               while (lru_order.size() > 0) send_request(lrus_pkg::OP_EVICT, any_frame());
               repeat ($urandom_range(1, 3)) send_request(lrus_pkg::OP_EVICT, any_frame());
            end
            default: begin
               repeat ($urandom_range(5, 15))
                  send_request(logic'($urandom_range(0, 1)), any_frame());
            end
         endcase
      end
      quiet_stretch = 1'b0;
      req_if.valid = 1'b0;

      while (expected_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests: %0d evictions, %0d evicts on an empty stack,",
               sent_count, eviction_count, empty_evict_count);
      $display("%0d frames dropped by a full stack of %0d; %0d responses checked, %0d mismatches.",
               full_drop_count, STACK_DEPTH, checked_count, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
